// ----- rtl/core/assert_macros.svh -----
// assertion helpers used by the parser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked also during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/tdsrp_pkg.sv -----
// ----------------------------------------------------------------------------
// tdsrp_pkg
// types, codes and sizes for the table driven shift reduce parser
// ----------------------------------------------------------------------------
package tdsrp_pkg;

  localparam int STATES      = 32;
  localparam int SYMBOLS     = 64;
  localparam int STACK_DEPTH = 32;
  localparam int REDUCE_LIMIT = 31;

  localparam int ST_W   = 5;
  localparam int SYM_W  = 6;
  localparam int CNT_W  = 6;
  localparam int RED_W  = 6;
  localparam int CELL_W = ST_W + SYM_W;

  typedef enum logic [2:0] {
    CMD_GOTO   = 3'd0,
    CMD_RULE   = 3'd1,
    CMD_REDUCE = 3'd2,
    CMD_START  = 3'd3,
    CMD_TOKEN  = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    OC_ACK      = 4'd0,
    OC_REDUCE   = 4'd1,
    OC_SHIFTED  = 4'd2,
    OC_ACCEPT   = 4'd3,
    OC_NO_TRANS = 4'd4,
    OC_OVERFLOW = 4'd5,
    OC_UNDERFLOW = 4'd6,
    OC_CAP      = 4'd7,
    OC_ERR_SYM  = 4'd8,
    OC_NOT_PARSING = 4'd9
  } outcome_t;

  localparam logic [0:0] CFG_ACCEPT = 1'b0;
  localparam logic [0:0] CFG_ERROR  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_GOTO_RD, S_GOTO_CHK, S_RED_RD, S_RED_CHK, S_EMIT, S_FINAL
  } state_t;

  typedef struct packed {
    logic [2:0] command;
    logic [4:0] table_state;
    logic [5:0] token_kind;
    logic [5:0] next_token_kind;
    logic [4:0] goto_target;
    logic       entry_valid;
    logic [5:0] rule_pops;
    logic [5:0] rule_result_symbol;
    logic       rule_has_action;
  } in_item_t;

  typedef struct packed {
    logic [3:0] outcome;
    logic [4:0] rule_state;
    logic [5:0] reduced_symbol;
    logic       action_fired;
    logic [5:0] stack_depth;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [5:0] pops;
    logic [5:0] sym;
    logic       act;
  } rule_t;

endpackage

// ----- rtl/core/table_driven_shift_reduce_parser.sv -----
// ----------------------------------------------------------------------------
// table_driven_shift_reduce_parser
// lr shift/reduce automaton with goto table, reduce bits, rules and state stack
// ----------------------------------------------------------------------------
// channel  dir  handshake       payload
// in       in   valid / stall   tdsrp_pkg::in_item_t
// out      out  valid / stall   tdsrp_pkg::out_item_t
// cfg      in   write enable    accept / error symbol
// table writes and start are applied in S_FINAL along with the output beat
// a token steps S_GOTO_RD, S_GOTO_CHK, S_RED_RD and S_RED_CHK, then S_EMIT for
// its final beat when it only shifts; each reduction repeats these four states
// after reset a clearing pass zeroes the 2048 table cells before the first item
// a stalled result holds the next output step; input is taken only when idle
module table_driven_shift_reduce_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tdsrp_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tdsrp_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [5:0]           cfg_data
);

  `include "assert_macros.svh"

  localparam int CELLS = tdsrp_pkg::STATES * tdsrp_pkg::SYMBOLS;

  logic [5:0] goto_mem [CELLS];
  logic       red_mem  [CELLS];
  tdsrp_pkg::rule_t rule_mem [tdsrp_pkg::STATES];
  logic [tdsrp_pkg::ST_W-1:0] stk_mem [tdsrp_pkg::STACK_DEPTH];

  tdsrp_pkg::state_t state_r, state_nxt;
  tdsrp_pkg::in_item_t item_r, item_nxt;
  tdsrp_pkg::out_item_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [tdsrp_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic parsing_r, parsing_nxt;
  logic [tdsrp_pkg::RED_W-1:0] red_cnt_r, red_cnt_nxt;
  logic [tdsrp_pkg::SYM_W-1:0] sym_r, sym_nxt;
  logic [tdsrp_pkg::ST_W-1:0] top_r, top_nxt;
  logic [tdsrp_pkg::CELL_W:0] clr_r, clr_nxt;
  logic [5:0] acc_sym_r, err_sym_r;
  logic [3:0] fin_oc_r, fin_oc_nxt;

  logic [5:0] goto_rd;
  logic       red_rd;
  tdsrp_pkg::rule_t rule_rd;
  logic [tdsrp_pkg::ST_W-1:0] stk_rd;

  logic mem_we_goto, mem_we_red, mem_we_stk;
  logic [tdsrp_pkg::CELL_W-1:0] cell_addr;
  logic [5:0] goto_wd;
  logic red_wd;
  logic [tdsrp_pkg::ST_W-1:0] stk_wa, stk_wd;
  logic rule_we;
  logic [tdsrp_pkg::ST_W-1:0] rule_wa;
  tdsrp_pkg::rule_t rule_wd;

  always_ff @(posedge clk) begin
    if (mem_we_goto) goto_mem[cell_addr] <= goto_wd;
    goto_rd <= goto_mem[cell_addr];
    if (mem_we_red) red_mem[cell_addr] <= red_wd;
    red_rd <= red_mem[cell_addr];
    if (rule_we) rule_mem[rule_wa] <= rule_wd;
    rule_rd <= rule_mem[top_r];
    if (mem_we_stk) stk_mem[stk_wa] <= stk_wd;
    stk_rd <= stk_mem[stk_wa];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_sym_r <= 6'd62;
      err_sym_r <= 6'd63;
    end else if (cfg_we) begin
      if (cfg_index == tdsrp_pkg::CFG_ACCEPT) acc_sym_r <= cfg_data;
      else err_sym_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdsrp_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
      cnt_r <= '0;
      parsing_r <= 1'b0;
      clr_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r <= cnt_nxt;
      parsing_r <= parsing_nxt;
      clr_r <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    out_r <= out_nxt;
    red_cnt_r <= red_cnt_nxt;
    sym_r <= sym_nxt;
    top_r <= top_nxt;
    fin_oc_r <= fin_oc_nxt;
  end

  function automatic tdsrp_pkg::out_item_t mk_out(logic [3:0] oc, logic [4:0] rs,
      logic [5:0] sy, logic ac, logic [5:0] d, logic l);
    tdsrp_pkg::out_item_t o;
    o.outcome = oc; o.rule_state = rs; o.reduced_symbol = sy;
    o.action_fired = ac; o.stack_depth = d; o.last = l;
    return o;
  endfunction

  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r;
    cnt_nxt = cnt_r;
    parsing_nxt = parsing_r;
    red_cnt_nxt = red_cnt_r;
    sym_nxt = sym_r;
    top_nxt = top_r;
    clr_nxt = clr_r;
    fin_oc_nxt = fin_oc_r;
    mem_we_goto = 1'b0;
    mem_we_red = 1'b0;
    mem_we_stk = 1'b0;
    rule_we = 1'b0;
    rule_wa = item_r.table_state;
    rule_wd = {item_r.rule_pops, item_r.rule_result_symbol, item_r.rule_has_action};
    cell_addr = {top_r, sym_r};
    goto_wd = {item_r.entry_valid, item_r.goto_target};
    red_wd = item_r.entry_valid;
    stk_wa = cnt_r[tdsrp_pkg::ST_W-1:0] - 5'd1;
    stk_wd = goto_rd[4:0];
    in_stall = 1'b1;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      tdsrp_pkg::S_CLEAR: begin
        cell_addr = clr_r[tdsrp_pkg::CELL_W-1:0];
        goto_wd = '0;
        red_wd = 1'b0;
        mem_we_goto = 1'b1;
        mem_we_red = 1'b1;
        rule_we = 1'b1;
        rule_wa = clr_r[tdsrp_pkg::ST_W-1:0];
        rule_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r[tdsrp_pkg::CELL_W-1:0] == '1) state_nxt = tdsrp_pkg::S_IDLE;
      end
      tdsrp_pkg::S_IDLE: begin
        in_stall = out_valid_r;
        if (in_valid && !out_valid_r) begin
          item_nxt = in_data;
          case (in_data.command)
            tdsrp_pkg::CMD_TOKEN: begin
              if (!parsing_r) begin
                out_nxt = mk_out(tdsrp_pkg::OC_NOT_PARSING, '0, '0, 1'b0, cnt_r, 1'b1);
                out_valid_nxt = 1'b1;
              end else begin
                sym_nxt = in_data.token_kind;
                red_cnt_nxt = '0;
                state_nxt = tdsrp_pkg::S_GOTO_RD;
              end
            end
            default: begin
              state_nxt = tdsrp_pkg::S_FINAL;
              fin_oc_nxt = tdsrp_pkg::OC_ACK;
            end
          endcase
        end
      end
      tdsrp_pkg::S_FINAL: begin
        case (item_r.command)
          tdsrp_pkg::CMD_GOTO: begin
            cell_addr = {item_r.table_state, item_r.token_kind};
            mem_we_goto = 1'b1;
          end
          tdsrp_pkg::CMD_RULE: rule_we = 1'b1;
          tdsrp_pkg::CMD_REDUCE: begin
            cell_addr = {item_r.table_state, item_r.token_kind};
            mem_we_red = 1'b1;
          end
          tdsrp_pkg::CMD_START: begin
            stk_wa = '0;
            stk_wd = item_r.table_state;
            mem_we_stk = 1'b1;
            cnt_nxt = 6'd1;
            parsing_nxt = 1'b1;
          end
          default: ;
        endcase
        if (!out_valid_r) begin
          out_nxt = mk_out(fin_oc_r, '0, '0, 1'b0,
                           (item_r.command == tdsrp_pkg::CMD_START) ? 6'd1 : cnt_r, 1'b1);
          out_valid_nxt = 1'b1;
          state_nxt = tdsrp_pkg::S_IDLE;
        end
      end
      // read top of stack, then goto cell
      tdsrp_pkg::S_GOTO_RD: begin
        cell_addr = {stk_rd, sym_r};
        if (cnt_r == '0) begin
          fin_oc_nxt = tdsrp_pkg::OC_UNDERFLOW;
          parsing_nxt = 1'b0;
          state_nxt = tdsrp_pkg::S_EMIT;
        end else begin
          top_nxt = stk_rd;
          state_nxt = tdsrp_pkg::S_GOTO_CHK;
        end
      end
      tdsrp_pkg::S_GOTO_CHK: begin
        // goto_rd holds the cell read from the address set in S_GOTO_RD
        state_nxt = tdsrp_pkg::S_RED_RD;
        if (!goto_rd[5]) begin
          fin_oc_nxt = tdsrp_pkg::OC_NO_TRANS;
          parsing_nxt = 1'b0;
          state_nxt = tdsrp_pkg::S_EMIT;
        end else if (cnt_r >= 6'(tdsrp_pkg::STACK_DEPTH)) begin
          fin_oc_nxt = tdsrp_pkg::OC_OVERFLOW;
          parsing_nxt = 1'b0;
          state_nxt = tdsrp_pkg::S_EMIT;
        end else begin
          stk_wa = cnt_r[tdsrp_pkg::ST_W-1:0];
          mem_we_stk = 1'b1;
          cnt_nxt = cnt_r + 6'd1;
          top_nxt = goto_rd[4:0];
          sym_nxt = item_r.next_token_kind;
        end
      end
      tdsrp_pkg::S_RED_RD: begin
        state_nxt = tdsrp_pkg::S_RED_CHK;
      end
      tdsrp_pkg::S_RED_CHK: begin
        if (!out_valid_r) begin
          if (!red_rd) begin
            fin_oc_nxt = tdsrp_pkg::OC_SHIFTED;
            state_nxt = tdsrp_pkg::S_EMIT;
          end else if (red_cnt_r >= 6'(tdsrp_pkg::REDUCE_LIMIT)) begin
            fin_oc_nxt = tdsrp_pkg::OC_CAP;
            parsing_nxt = 1'b0;
            state_nxt = tdsrp_pkg::S_EMIT;
          end else if (rule_rd.pops > cnt_r) begin
            fin_oc_nxt = tdsrp_pkg::OC_UNDERFLOW;
            parsing_nxt = 1'b0;
            state_nxt = tdsrp_pkg::S_EMIT;
          end else begin
            // read the new top of stack for the next goto
            stk_wa = cnt_r[tdsrp_pkg::ST_W-1:0] - rule_rd.pops[tdsrp_pkg::ST_W-1:0] - 5'd1;
            cnt_nxt = cnt_r - rule_rd.pops;
            red_cnt_nxt = red_cnt_r + 6'd1;
            out_nxt = mk_out(tdsrp_pkg::OC_REDUCE, top_r, rule_rd.sym, rule_rd.act,
                             cnt_r - rule_rd.pops, 1'b0);
            out_valid_nxt = 1'b1;
            sym_nxt = rule_rd.sym;
            if (rule_rd.sym == acc_sym_r) begin
              fin_oc_nxt = tdsrp_pkg::OC_ACCEPT;
              parsing_nxt = 1'b0;
              state_nxt = tdsrp_pkg::S_EMIT;
            end else if (rule_rd.sym == err_sym_r) begin
              fin_oc_nxt = tdsrp_pkg::OC_ERR_SYM;
              parsing_nxt = 1'b0;
              state_nxt = tdsrp_pkg::S_EMIT;
            end else begin
              state_nxt = tdsrp_pkg::S_GOTO_RD;
            end
          end
        end
      end
      tdsrp_pkg::S_EMIT: begin
        if (!out_valid_r) begin
          out_nxt = mk_out(fin_oc_r, '0, '0, 1'b0, cnt_r, 1'b1);
          out_valid_nxt = 1'b1;
          state_nxt = tdsrp_pkg::S_IDLE;
        end
      end
      default: state_nxt = tdsrp_pkg::S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  `ASSERT_CLK(a_depth_max, clk, rst_n, cnt_r <= 6'(tdsrp_pkg::STACK_DEPTH), "stack count above depth")
  `ASSERT_CLK(a_idle_take, clk, rst_n, (!in_stall) |-> (state_r == tdsrp_pkg::S_IDLE), "input taken while busy")
  `ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid_r && out_stall) |=> $stable(out_r), "result changed while stalled")
  `ASSERT_CLK(a_red_cap, clk, rst_n, red_cnt_r <= 6'(tdsrp_pkg::REDUCE_LIMIT) || state_r == tdsrp_pkg::S_IDLE || state_r == tdsrp_pkg::S_CLEAR || state_r == tdsrp_pkg::S_FINAL, "reduce count past cap")

endmodule
